// ===== src/two_class_fifo_oldest_first_unit_defines.svh =====
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge unless dis is high.
`define TAC_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge unless dis is high.
`define TAC_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tac_pkg.sv =====
`default_nettype none

package tac_pkg;

  // Default sizes of the two class queues.
  localparam int TAC_QUEUE_DEPTH = 16;
  localparam int TAC_STAMP_BITS  = 16;

  // Fixed field widths on the channels.
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int STAMP_W  = 16;
  localparam int STATUS_W = 3;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes.
  localparam op_t OP_ENQ      = 2'd0;
  localparam op_t OP_DEQ_ONE  = 2'd1;
  localparam op_t OP_DEQ_ZERO = 2'd2;
  localparam op_t OP_DEQ_ANY  = 2'd3;

  // Item classes.
  localparam kind_t KIND_CAT = 2'd0;
  localparam kind_t KIND_DOG = 2'd1;

  // Result status codes.
  localparam status_t ST_ENQ      = 3'd0;
  localparam status_t ST_DEQ      = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_BADCLASS = 3'd4;

  // Per-cycle control of one queue cell.
  typedef struct packed {
    logic shift;
    logic push;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/tac_if.sv =====
`default_nettype none

// Request channel: one operation per transaction.
interface tac_in_if
  import tac_pkg::*;
;
  logic   valid;
  logic   ready;
  op_t    op;
  kind_t  animal_kind;
  stamp_t order_stamp;

  modport source (output valid, output op, output animal_kind, output order_stamp,
                  input ready);
  modport sink (input valid, input op, input animal_kind, input order_stamp,
                output ready);
endinterface

// Result channel: one result per transaction.
interface tac_out_if
  import tac_pkg::*;
;
  logic    valid;
  logic    ready;
  status_t status;
  logic    out_kind;
  stamp_t  out_stamp;

  modport source (output valid, output status, output out_kind, output out_stamp,
                  input ready);
  modport sink (input valid, input status, input out_kind, input out_stamp,
                output ready);
endinterface

`default_nettype wire

// ===== src/tac_cell.sv =====
`default_nettype none

module tac_cell
  import tac_pkg::*;
#(
  parameter int STAMP_BITS = TAC_STAMP_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cell_ctl_t             ctl,
  input  wire logic                  prev_valid,
  input  wire logic                  nbr_valid,
  input  wire logic [STAMP_BITS-1:0] nbr_stamp,
  input  wire logic [STAMP_BITS-1:0] wr_stamp,
  output logic                       valid,
  output logic [STAMP_BITS-1:0]      stamp
);

  logic                  valid_r, valid_nxt;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;
  logic                  take_push;

  // A push lands in the first empty cell, the one whose upstream neighbor is full.
  assign take_push = ctl.push && !valid_r && prev_valid;

  // On a pop every cell takes its downstream neighbor's contents.
  always_comb begin
    valid_nxt = valid_r;
    stamp_nxt = stamp_r;
    if (ctl.shift) begin
      valid_nxt = nbr_valid;
      stamp_nxt = nbr_stamp;
    end else if (take_push) begin
      valid_nxt = 1'b1;
      stamp_nxt = wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
  end

  assign valid = valid_r;
  assign stamp = stamp_r;

endmodule

`default_nettype wire

// ===== src/tac_queue.sv =====
`default_nettype none

module tac_queue
  import tac_pkg::*;
#(
  parameter int QUEUE_DEPTH = TAC_QUEUE_DEPTH,
  parameter int STAMP_BITS  = TAC_STAMP_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic                  pop,
  input  wire logic [STAMP_BITS-1:0] wr_stamp,
  output logic                       head_valid,
  output logic [STAMP_BITS-1:0]      head_stamp,
  output logic                       full
);

  logic                  valid_w [QUEUE_DEPTH+1];
  logic [STAMP_BITS-1:0] stamp_w [QUEUE_DEPTH+1];
  logic                  prev_w  [QUEUE_DEPTH];
  cell_ctl_t             ctl;

  assign ctl.shift = pop;
  assign ctl.push  = push;

  // Beyond the tail the chain feeds in an empty cell.
  assign valid_w[QUEUE_DEPTH] = 1'b0;
  assign stamp_w[QUEUE_DEPTH] = '0;

  // Cell 0 is the head; data moves toward it on every pop.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_w[i] = 1'b1;
    end else begin : g_body
      assign prev_w[i] = valid_w[i-1];
    end

    tac_cell #(
      .STAMP_BITS(STAMP_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_valid(prev_w[i]),
      .nbr_valid (valid_w[i+1]),
      .nbr_stamp (stamp_w[i+1]),
      .wr_stamp  (wr_stamp),
      .valid     (valid_w[i]),
      .stamp     (stamp_w[i])
    );
  end

  assign head_valid = valid_w[0];
  assign head_stamp = stamp_w[0];
  assign full       = valid_w[QUEUE_DEPTH-1];

endmodule

`default_nettype wire

// ===== src/two_class_fifo_oldest_first_unit.sv =====
// Two-class FIFO store with oldest-first retrieval.
// Requests arrive on in_ch (op, animal_kind, order_stamp) with a valid/ready
// handshake; every accepted request gives exactly one result on out_ch
// (status, out_kind, out_stamp). Enqueue appends a stamp to the class zero or
// class one queue; the class dequeues pop that queue's head; dequeue-any pops
// the head with the smaller stamp, class one on a tie.
// Each queue is a row of QUEUE_DEPTH cells with the head in cell 0; a pop
// shifts every cell one place toward the head in the same cycle.
// The result is loaded into the output register by the request transaction.
// Throughput: one request per cycle while the receiver takes each result,
// set by the cell shift and the one head-stamp compare.
// When the receiver stalls, the result stays in the output register and
// in_ch.ready is low until it is taken; nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues and the output register;
// no clearing pass is needed, the block accepts requests right after reset.
`default_nettype none

module two_class_fifo_oldest_first_unit
  import tac_pkg::*;
#(
  parameter int QUEUE_DEPTH = TAC_QUEUE_DEPTH,
  parameter int STAMP_BITS  = TAC_STAMP_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tac_in_if.sink     in_ch,
  tac_out_if.source  out_ch
);

  logic                  accept;
  logic                  push_z, push_o, pop_z, pop_o;
  logic                  z_valid, o_valid, z_full, o_full;
  logic [STAMP_BITS-1:0] z_stamp, o_stamp, in_stamp;
  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic                  kind_r, kind_nxt;
  stamp_t                stamp_r, stamp_nxt;

  // A new request is taken whenever the output register is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_stamp    = STAMP_BITS'(in_ch.order_stamp);

  // Decode the request and pick the queue to push or pop.
  always_comb begin
    push_z     = 1'b0;
    push_o     = 1'b0;
    pop_z      = 1'b0;
    pop_o      = 1'b0;
    status_nxt = ST_EMPTY;
    case (in_ch.op)
      OP_ENQ: begin
        if (in_ch.animal_kind == KIND_CAT) begin
          status_nxt = z_full ? ST_FULL : ST_ENQ;
          push_z     = !z_full;
        end else if (in_ch.animal_kind == KIND_DOG) begin
          status_nxt = o_full ? ST_FULL : ST_ENQ;
          push_o     = !o_full;
        end else begin
          status_nxt = ST_BADCLASS;
        end
      end
      OP_DEQ_ONE: begin
        pop_o = o_valid;
      end
      OP_DEQ_ZERO: begin
        pop_z = z_valid;
      end
      OP_DEQ_ANY: begin
        if (z_valid && o_valid) begin
          pop_z = z_stamp < o_stamp;
          pop_o = !(z_stamp < o_stamp);
        end else begin
          pop_z = z_valid;
          pop_o = o_valid;
        end
      end
      default: begin
        status_nxt = ST_EMPTY;
      end
    endcase
    if (pop_z || pop_o) begin
      status_nxt = ST_DEQ;
    end
  end

  // Result payload: the popped head, zero for every other outcome.
  always_comb begin
    kind_nxt  = pop_o;
    stamp_nxt = '0;
    if (pop_z) begin
      stamp_nxt = STAMP_W'(z_stamp);
    end else if (pop_o) begin
      stamp_nxt = STAMP_W'(o_stamp);
    end
  end

  // Class zero (cat) queue.
  tac_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_zero_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && push_z),
    .pop       (accept && pop_z),
    .wr_stamp  (in_stamp),
    .head_valid(z_valid),
    .head_stamp(z_stamp),
    .full      (z_full)
  );

  // Class one (dog) queue.
  tac_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_one_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && push_o),
    .pop       (accept && pop_o),
    .wr_stamp  (in_stamp),
    .head_valid(o_valid),
    .head_stamp(o_stamp),
    .full      (o_full)
  );

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload is loaded only on a request transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      kind_r   <= kind_nxt;
      stamp_r  <= stamp_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_kind  = kind_r;
  assign out_ch.out_stamp = stamp_r;

endmodule

`default_nettype wire

// ===== src/tac_checker.sv =====
`default_nettype none
`include "two_class_fifo_oldest_first_unit_defines.svh"

module tac_checker
  import tac_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire status_t out_status,
  input wire logic    out_kind,
  input wire stamp_t  out_stamp
);

  // A stalled result keeps its payload.
  `TAC_ASSERT_NEXT(a_hold, clk, !rst_n, out_valid && !out_ready, $stable(out_status) && $stable(out_kind) && $stable(out_stamp), "stalled result changed")

  // Every request transaction leaves a result in the output register.
  `TAC_ASSERT_NEXT(a_result, clk, !rst_n, in_valid && in_ready, out_valid, "request gave no result")

  // A waiting result is never overwritten by a new request.
  `TAC_ASSERT_NOW(a_no_overrun, clk, !rst_n, out_valid && !out_ready, !in_ready, "result would be overwritten")

  // Only a dequeue carries a class and a stamp.
  `TAC_ASSERT_NOW(a_zero_pay, clk, !rst_n, out_valid && out_status != ST_DEQ, !out_kind && out_stamp == '0, "payload on non-dequeue result")

  // Reset empties the output register.
  `TAC_ASSERT_NEXT(a_reset, clk, 1'b0, !rst_n, !out_valid, "result valid after reset")

endmodule

bind two_class_fifo_oldest_first_unit tac_checker u_tac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_status(out_ch.status),
  .out_kind  (out_ch.out_kind),
  .out_stamp (out_ch.out_stamp)
);

`default_nettype wire
